// ----- rtl/slx_pkg.sv -----
// shared types, character codes and the byte classifier of the source lexer
`timescale 1ns / 1ps

package slx_pkg;

  localparam int POS_BITS = 16;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_BSLASH     = 8'h5C;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_N          = 8'h6E;

  typedef enum logic [2:0] {
    TY_NONE      = 3'd0,
    TY_ALPHA     = 3'd1,
    TY_SPACE     = 3'd2,
    TY_CNTRL     = 3'd3,
    TY_DIGIT     = 3'd4,
    TY_PUNCT     = 3'd5,
    TY_QUOTE     = 3'd6,
    TY_DIRECTIVE = 3'd7
  } tok_type_t;

  // results an input item causes, in emission order from bnd to flush
  typedef struct packed {
    logic bnd;
    logic c0;
    logic c1;
    logic c2;
    logic flush;
  } step_mask_t;

  typedef struct packed {
    step_mask_t            steps;
    tok_type_t             bnd_type;
    tok_type_t             flush_type;
    logic [7:0]            first_byte;
    logic [POS_BITS-1:0]   line;
    logic [POS_BITS-1:0]   col;
  } slx_cmd_t;

  function automatic tok_type_t classify(input logic [7:0] b);
    tok_type_t t;
    if (b == CH_UNDERSCORE || (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
      t = TY_ALPHA;
    end else if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
      t = TY_SPACE;
    end else if (b < 8'h20 || b == 8'h7F) begin
      t = TY_CNTRL;
    end else if (b >= 8'h30 && b <= 8'h39) begin
      t = TY_DIGIT;
    end else if (b < 8'h7F) begin
      t = TY_PUNCT;
    end else begin
      t = TY_NONE;
    end
    return t;
  endfunction

endpackage

// ----- rtl/slx_in_if.sv -----
// input channel of the source lexer: one source byte per item
`timescale 1ns / 1ps

interface slx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_text;

  modport source (output valid, output source_byte, output end_of_text, input ready);
  modport sink   (input valid, input source_byte, input end_of_text, output ready);
endinterface

// ----- rtl/slx_out_if.sv -----
// result channel of the source lexer: one content or boundary event per item
`timescale 1ns / 1ps

interface slx_out_if;
  logic        valid;
  logic        ready;
  logic        event_kind;
  logic [7:0]  content_byte;
  logic [2:0]  closed_type;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic        last_of_run;

  modport source (output valid, output event_kind, output content_byte, output closed_type,
                  output start_line, output start_column, output last_of_run, input ready);
  modport sink   (input valid, input event_kind, input content_byte, input closed_type,
                  input start_line, input start_column, input last_of_run, output ready);
endinterface

// ----- rtl/slx_front.sv -----
// front end: classifies each byte, keeps token and position state, builds a command
`timescale 1ns / 1ps

module slx_front import slx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  slx_in_if.sink   in_ch,
  output slx_cmd_t cmd,
  output logic     cmd_valid,
  input  logic     cmd_full
);

  tok_type_t           tt_r, tt_nxt, tt_upd, cls;
  logic                esc_r, esc_nxt, esc_upd;
  logic [POS_BITS-1:0] line_r, line_nxt, line_upd;
  logic [POS_BITS-1:0] col_r, col_nxt, col_upd;
  logic [7:0]          b;
  logic [7:0]          first_byte;
  step_mask_t          steps;
  logic                acc;

  assign in_ch.ready = !cmd_full;
  assign acc         = in_ch.valid && !cmd_full;

  always_comb begin
    b      = in_ch.source_byte;
    cls    = classify(b);
    line_upd = line_r;
    col_upd  = col_r;
    // newline restarts the column, everything else advances it up to its maximum
    if (b == CH_LF) begin
      if (line_r != POS_MAX) line_upd = line_r + POS_ONE;
      col_upd = POS_ONE;
    end else if (col_r != POS_MAX) begin
      col_upd = col_r + POS_ONE;
    end

    steps      = '0;
    first_byte = b;
    tt_upd     = tt_r;
    esc_upd    = esc_r;
    case (tt_r)
      TY_DIRECTIVE: begin
        if (b == CH_LF) begin
          steps.bnd = 1'b1;
          tt_upd    = TY_NONE;
        end
        steps.c0 = 1'b1;
      end
      TY_QUOTE: begin
        if (b == CH_BSLASH) begin
          esc_upd  = 1'b1;
          steps.c0 = 1'b1;
        end else if (b == CH_QUOTE && !esc_r) begin
          steps.bnd = 1'b1;
          tt_upd    = TY_NONE;
        end else if (b == CH_LF) begin
          // newline inside quotes expands to backslash, n, newline
          steps.c0   = 1'b1;
          steps.c1   = 1'b1;
          steps.c2   = 1'b1;
          first_byte = CH_BSLASH;
        end else begin
          esc_upd  = 1'b0;
          steps.c0 = 1'b1;
        end
      end
      default: begin
        if (cls != tt_r || tt_r == TY_NONE || cls == TY_PUNCT) begin
          steps.bnd = (tt_r != TY_NONE);
          if (b == CH_QUOTE) begin
            tt_upd = TY_QUOTE;
          end else begin
            tt_upd   = (b == CH_HASH) ? TY_DIRECTIVE : cls;
            steps.c0 = 1'b1;
          end
        end else begin
          steps.c0 = 1'b1;
        end
      end
    endcase
    steps.flush = in_ch.end_of_text;

    cmd.steps      = steps;
    cmd.bnd_type   = tt_r;
    cmd.flush_type = tt_upd;
    cmd.first_byte = first_byte;
    cmd.line       = line_upd;
    cmd.col        = col_upd;

    // last byte of the text returns all state to its reset values
    if (in_ch.end_of_text) begin
      tt_nxt   = TY_NONE;
      esc_nxt  = 1'b0;
      line_nxt = POS_ONE;
      col_nxt  = POS_ONE;
    end else begin
      tt_nxt   = tt_upd;
      esc_nxt  = esc_upd;
      line_nxt = line_upd;
      col_nxt  = col_upd;
    end
  end

  assign cmd_valid = acc && (steps != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tt_r   <= TY_NONE;
      esc_r  <= 1'b0;
      line_r <= POS_ONE;
      col_r  <= POS_ONE;
    end else if (acc) begin
      tt_r   <= tt_nxt;
      esc_r  <= esc_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

`ifndef SYNTHESIS
  a_eot_resets: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_ch.end_of_text |=> tt_r == TY_NONE && !esc_r && line_r == POS_ONE
                                 && col_r == POS_ONE)
    else $error("state not cleared after end of text");
  a_quote_only_escape: assert property (@(posedge clk) disable iff (!rst_n)
    tt_r != TY_QUOTE |-> !esc_r)
    else $error("escape flag set outside a quote");
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid |-> !cmd_full)
    else $error("command offered while the queue is full");
`endif

endmodule

// ----- rtl/slx_cmd_fifo.sv -----
// short command queue between the front end and the result sequencer
`timescale 1ns / 1ps

module slx_cmd_fifo import slx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  slx_cmd_t din,
  output logic     full,
  output logic     valid,
  output slx_cmd_t dout,
  input  logic     pop
);

  slx_cmd_t           mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid   = (count_r != '0);
  assign dout    = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= din;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("command pushed into a full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue count beyond depth");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow a push");
`endif

endmodule

// ----- rtl/slx_back.sv -----
// back end: expands each command into result items through an output register
`timescale 1ns / 1ps

module slx_back import slx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  slx_cmd_t cmd,
  input  logic     cmd_valid,
  output logic     cmd_pop,
  slx_out_if.source out_ch
);

  slx_cmd_t   cur_r;
  step_mask_t steps_r, steps_nxt, steps_left;
  logic       busy, load;
  logic       out_valid_r;
  logic       kind_r, kind_nxt;
  logic [7:0] byte_r, byte_nxt;
  tok_type_t  type_r, type_nxt;
  logic [15:0] line_r, col_r, line_nxt, col_nxt;
  logic       last_r;

  assign busy = (steps_r != '0);
  assign load = busy && (!out_valid_r || out_ch.ready);

  always_comb begin
    steps_left = steps_r;
    kind_nxt   = 1'b0;
    byte_nxt   = 8'h00;
    type_nxt   = TY_NONE;
    line_nxt   = 16'h0000;
    col_nxt    = 16'h0000;
    // earliest pending step in emission order goes out first
    if (steps_r.bnd) begin
      steps_left.bnd = 1'b0;
      kind_nxt       = 1'b1;
      type_nxt       = cur_r.bnd_type;
      line_nxt       = 16'(cur_r.line);
      col_nxt        = 16'(cur_r.col);
    end else if (steps_r.c0) begin
      steps_left.c0 = 1'b0;
      byte_nxt      = cur_r.first_byte;
    end else if (steps_r.c1) begin
      steps_left.c1 = 1'b0;
      byte_nxt      = CH_N;
    end else if (steps_r.c2) begin
      steps_left.c2 = 1'b0;
      byte_nxt      = CH_LF;
    end else if (steps_r.flush) begin
      steps_left.flush = 1'b0;
      kind_nxt         = 1'b1;
      type_nxt         = cur_r.flush_type;
      line_nxt         = 16'(cur_r.line);
      col_nxt          = 16'(cur_r.col);
    end
  end

  assign cmd_pop = cmd_valid && (!busy || (load && steps_left == '0));

  always_comb begin
    steps_nxt = steps_r;
    if (cmd_pop) steps_nxt = cmd.steps;
    else if (load) steps_nxt = steps_left;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      steps_r <= steps_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) cur_r <= cmd;
    if (load) begin
      kind_r <= kind_nxt;
      byte_r <= byte_nxt;
      type_r <= type_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      last_r <= (steps_left == '0);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_kind   = kind_r;
  assign out_ch.content_byte = byte_r;
  assign out_ch.closed_type  = type_r;
  assign out_ch.start_line   = line_r;
  assign out_ch.start_column = col_r;
  assign out_ch.last_of_run  = last_r;

`ifndef SYNTHESIS
  a_no_pop_midway: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop && busy |-> load && steps_left == '0)
    else $error("new command taken before the current one finished");
  a_last_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    load && steps_left == '0 && !cmd_pop |=> !busy)
    else $error("steps left after the final item of a byte");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.event_kind)
                                      && $stable(out_ch.content_byte)
                                      && $stable(out_ch.last_of_run))
    else $error("waiting item changed before it was taken");
`endif

endmodule

// ----- rtl/source_lexer_stream_core.sv -----
// top level of the character-class source lexer
`timescale 1ns / 1ps

// usage:
//   in_ch takes one source byte per item with an end_of_text flag on the final byte
//   out_ch gives content events (event_kind 0) and token boundary events
//   (event_kind 1: closed type plus start line and column of the new token);
//   last_of_run marks the final item caused by one input byte
//   a byte causes zero to four items; a byte causing none leaves no trace at out_ch
// timing:
//   a byte accepted passes the command queue, the back end's command register and
//   the output register before its first item is shown
//   the front end takes one byte every cycle while the command queue has room;
//   the back end issues one item per cycle while out_ch.ready allows, so sustained
//   rate is set by the number of items per byte
// reset:
//   synchronous active-low rst_n empties the queue and the output register and
//   returns token type none, line 1, column 1; no initialisation pass is needed
// stalls:
//   a low out_ch.ready holds the output register; the four-entry command queue
//   keeps taking bytes until it fills, then in_ch.ready drops
module source_lexer_stream_core import slx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  slx_in_if.sink    in_ch,
  slx_out_if.source out_ch
);

  // command from the classifier into the queue
  slx_cmd_t push_cmd;
  logic     push_valid;
  logic     q_full;

  // command from the queue into the result sequencer
  slx_cmd_t pop_cmd;
  logic     pop_valid;
  logic     pop_take;

  // classification, token state and line/column tracking
  slx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (push_cmd),
    .cmd_valid (push_valid),
    .cmd_full  (q_full)
  );

  // decouples byte intake from result expansion
  slx_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push_valid),
    .din   (push_cmd),
    .full  (q_full),
    .valid (pop_valid),
    .dout  (pop_cmd),
    .pop   (pop_take)
  );

  // one result item per cycle into the output register while out_ch.ready allows
  slx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (pop_cmd),
    .cmd_valid (pop_valid),
    .cmd_pop   (pop_take),
    .out_ch    (out_ch)
  );

endmodule
